/* sv/scad_pkg.sv */
// ----------------------------------------------------------------------------
// scad_pkg: shared types and constants for the stick command arm/disarm block
// Holds the field widths, the register map, the reset values and the
// payload structures that the coder and the top level both use.
// ----------------------------------------------------------------------------
package scad_pkg;

  localparam int unsigned NUM_CHAN   = 4;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned CODE_W     = 2 * NUM_CHAN;
  localparam int unsigned HOLD_W     = 8;
  localparam int unsigned IDLE_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [HOLD_W-1:0] HOLD_SATURATE = 8'd250;
  localparam logic [HOLD_W-1:0] HOLD_TRIGGER  = 8'd150;

  // Within each 2-bit channel code: upper bit above min, lower bit below max.
  localparam int unsigned BIT_ABOVE_MIN = 1;
  localparam int unsigned BIT_BELOW_MAX = 0;

  localparam logic [PULSE_W-1:0] MIN_THR_RESET    = 16'd1100;
  localparam logic [PULSE_W-1:0] MAX_THR_RESET    = 16'd1900;
  localparam logic [CODE_W-1:0]  ARM_PAT_RESET    = 8'd111;
  localparam logic [CODE_W-1:0]  DISARM_PAT_RESET = 8'd95;
  localparam logic [CODE_W-1:0]  IDLE_PAT_RESET   = 8'd127;
  localparam logic [IDLE_W-1:0]  AUTO_LIMIT_RESET = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_THRESHOLD     = 3'd0,
    CFG_MAX_THRESHOLD     = 3'd1,
    CFG_ARM_PATTERN       = 3'd2,
    CFG_DISARM_PATTERN    = 3'd3,
    CFG_IDLE_PATTERN      = 3'd4,
    CFG_AUTO_DISARM_LIMIT = 3'd5
  } scad_cfg_idx_t;

  typedef logic [PULSE_W-1:0] scad_pulse_t;
  typedef scad_pulse_t [NUM_CHAN-1:0] scad_pulses_t;

  typedef struct packed {
    logic [PULSE_W-1:0] min_threshold;
    logic [PULSE_W-1:0] max_threshold;
  } scad_thr_t;

  typedef struct packed {
    logic              armed_now;
    logic              arm_event;
    logic              disarm_event;
    logic              auto_disarm_event;
    logic [CODE_W-1:0] stick_code;
  } scad_result_t;

endpackage

/* sv/scad_if.sv */
// ----------------------------------------------------------------------------
// scad_if: valid/ready channels of the stick command arm/disarm block
// scad_in_if carries one sample of four stick pulse widths; scad_out_if
// carries the arming status and the stick code of one processed sample.
// ----------------------------------------------------------------------------
interface scad_in_if;
  import scad_pkg::*;

  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] chan0_pulse;
  logic [PULSE_W-1:0] chan1_pulse;
  logic [PULSE_W-1:0] chan2_pulse;
  logic [PULSE_W-1:0] chan3_pulse;

  modport source (output valid, output chan0_pulse, output chan1_pulse,
                  output chan2_pulse, output chan3_pulse, input ready);
  modport sink   (input valid, input chan0_pulse, input chan1_pulse,
                  input chan2_pulse, input chan3_pulse, output ready);
endinterface

interface scad_out_if;
  import scad_pkg::*;

  logic              valid;
  logic              ready;
  logic              armed_now;
  logic              arm_event;
  logic              disarm_event;
  logic              auto_disarm_event;
  logic [CODE_W-1:0] stick_code;

  modport source (output valid, output armed_now, output arm_event,
                  output disarm_event, output auto_disarm_event,
                  output stick_code, input ready);
  modport sink   (input valid, input armed_now, input arm_event,
                  input disarm_event, input auto_disarm_event,
                  input stick_code, output ready);
endinterface

/* sv/scad_stick_coder.sv */
// ----------------------------------------------------------------------------
// scad_stick_coder: classifies four stick pulses into a packed code
// Each channel gives two bits, above-min and below-max; channel n sits in
// bits 2n+1:2n of the code.
// ----------------------------------------------------------------------------
module scad_stick_coder
  import scad_pkg::*;
(
  input  scad_pulses_t      pulses,
  input  scad_thr_t         thr,
  output logic [CODE_W-1:0] code
);

  always_comb begin
    code = '0;
    for (int n = 0; n < NUM_CHAN; n++) begin
      code[2*n + BIT_ABOVE_MIN] = (pulses[n] > thr.min_threshold);
      code[2*n + BIT_BELOW_MAX] = (pulses[n] < thr.max_threshold);
    end
  end

endmodule

/* sv/stick_command_arm_disarm.sv */
// ----------------------------------------------------------------------------
// stick_command_arm_disarm: arming by held stick command with idle timeout
// Top level of the block. Samples of four stick channels come in on in_ch;
// one status result per sample leaves on out_ch.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries four 16-bit pulse widths; a transfer takes place at a rising
//   edge with valid and ready both high. Each sample yields exactly one
//   result on out_ch: the armed flag, the arm, disarm and auto-disarm events
//   and the packed stick code.
//   A sample is captured in the input register on its transfer; its result
//   is loaded into the output register when that register is empty or being
//   read. One sample per cycle is sustained while out_ch.ready stays high;
//   the hold, idle and armed registers update as the result is loaded.
//   If the receiver stalls, the result is held and the input register can
//   still take one more sample; in_ch.ready drops only when both are full.
//   Configuration is written through cfg_we/cfg_index/cfg_data while the
//   block is idle; writes to an index past the register list are ignored.
//   Synchronous reset (rst_n low) empties both registers, restores the
//   register defaults and clears the hold count, idle count, last code and
//   armed flag, leaving the block disarmed.
// ----------------------------------------------------------------------------
module stick_command_arm_disarm
  import scad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  scad_in_if.sink               in_ch,
  scad_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [PULSE_W-1:0] min_thr_r;
  logic [PULSE_W-1:0] max_thr_r;
  logic [CODE_W-1:0]  arm_pat_r;
  logic [CODE_W-1:0]  disarm_pat_r;
  logic [CODE_W-1:0]  idle_pat_r;
  logic [IDLE_W-1:0]  auto_limit_r;

  // Block state.
  logic [CODE_W-1:0]  last_pat_r, last_pat_nxt;
  logic [HOLD_W-1:0]  hold_cnt_r, hold_cnt_nxt;
  logic [IDLE_W-1:0]  idle_cnt_r, idle_cnt_nxt;
  logic               armed_r, armed_nxt;

  // Pipeline registers.
  logic               s1_valid_r;
  scad_pulses_t       s1_pulses_r;
  logic               out_valid_r;
  scad_result_t       out_res_r, res_nxt;

  logic               advance;
  logic [CODE_W-1:0]  code;
  scad_thr_t          thr;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_thr_r    <= MIN_THR_RESET;
      max_thr_r    <= MAX_THR_RESET;
      arm_pat_r    <= ARM_PAT_RESET;
      disarm_pat_r <= DISARM_PAT_RESET;
      idle_pat_r   <= IDLE_PAT_RESET;
      auto_limit_r <= AUTO_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_THRESHOLD:     min_thr_r    <= cfg_data;
        CFG_MAX_THRESHOLD:     max_thr_r    <= cfg_data;
        CFG_ARM_PATTERN:       arm_pat_r    <= cfg_data[CODE_W-1:0];
        CFG_DISARM_PATTERN:    disarm_pat_r <= cfg_data[CODE_W-1:0];
        CFG_IDLE_PATTERN:      idle_pat_r   <= cfg_data[CODE_W-1:0];
        CFG_AUTO_DISARM_LIMIT: auto_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign thr.min_threshold = min_thr_r;
  assign thr.max_threshold = max_thr_r;

  scad_stick_coder u_coder (
    .pulses (s1_pulses_r),
    .thr    (thr),
    .code   (code)
  );

  always_comb begin
    logic armed_mid;
    logic ev_arm;
    logic ev_disarm;
    logic ev_auto;

    if (code == last_pat_r) begin
      hold_cnt_nxt = (hold_cnt_r < HOLD_SATURATE) ? hold_cnt_r + 1'b1 : hold_cnt_r;
    end else begin
      hold_cnt_nxt = '0;
    end
    last_pat_nxt = code;

    armed_mid = armed_r;
    ev_arm    = 1'b0;
    ev_disarm = 1'b0;
    if (hold_cnt_nxt == HOLD_TRIGGER) begin
      if (armed_r) begin
        if (code == disarm_pat_r) begin
          armed_mid = 1'b0;
          ev_disarm = 1'b1;
        end
      end else if (code == arm_pat_r) begin
        armed_mid = 1'b1;
        ev_arm    = 1'b1;
      end
    end

    // The idle timeout runs on the flag as it stands after the hold rule,
    // so a sample that arms can also time out at once.
    armed_nxt    = armed_mid;
    idle_cnt_nxt = idle_cnt_r;
    ev_auto      = 1'b0;
    if (armed_mid) begin
      if (code == idle_pat_r) begin
        if (idle_cnt_r < auto_limit_r) begin
          idle_cnt_nxt = idle_cnt_r + 1'b1;
        end else begin
          armed_nxt = 1'b0;
          ev_auto   = 1'b1;
        end
      end else begin
        idle_cnt_nxt = '0;
      end
    end

    res_nxt.armed_now         = armed_nxt;
    res_nxt.arm_event         = ev_arm;
    res_nxt.disarm_event      = ev_disarm;
    res_nxt.auto_disarm_event = ev_auto;
    res_nxt.stick_code        = code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_pat_r  <= '0;
      hold_cnt_r  <= '0;
      idle_cnt_r  <= '0;
      armed_r     <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          last_pat_r <= last_pat_nxt;
          hold_cnt_r <= hold_cnt_nxt;
          idle_cnt_r <= idle_cnt_nxt;
          armed_r    <= armed_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_pulses_r[0] <= in_ch.chan0_pulse;
      s1_pulses_r[1] <= in_ch.chan1_pulse;
      s1_pulses_r[2] <= in_ch.chan2_pulse;
      s1_pulses_r[3] <= in_ch.chan3_pulse;
    end
    if (advance && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.armed_now         = out_res_r.armed_now;
  assign out_ch.arm_event         = out_res_r.arm_event;
  assign out_ch.disarm_event      = out_res_r.disarm_event;
  assign out_ch.auto_disarm_event = out_res_r.auto_disarm_event;
  assign out_ch.stick_code        = out_res_r.stick_code;

  // The hold counter saturates and never passes its ceiling.
  a_hold_sat: assert property (@(posedge clk) disable iff (!rst_n)
    hold_cnt_r <= HOLD_SATURATE)
    else $error("hold counter above saturation value");

  // A held command cannot both arm and disarm on one sample.
  a_arm_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.arm_event && out_res_r.disarm_event))
    else $error("arm and disarm events on the same sample");

  // Any disarm event leaves the block disarmed.
  a_disarm_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.disarm_event || out_res_r.auto_disarm_event)
      |-> !out_res_r.armed_now)
    else $error("disarm event with armed flag set");

  // The reported flag matches the state once the result has been loaded.
  a_flag_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_valid_r |=> out_res_r.armed_now == armed_r)
    else $error("reported armed flag differs from state");

endmodule

/* tb/tb_stick_command_arm_disarm.sv */
// ----------------------------------------------------------------------------
// tb_stick_command_arm_disarm: self-checking bench for stick command arming
// Drives stick samples under random sender and receiver idling, keeps its
// own copy of the arming state to predict every status result, and checks
// each result field by field. Thresholds and patterns change between phases.
// ----------------------------------------------------------------------------
module tb_stick_command_arm_disarm;
  import scad_pkg::*;

  localparam int unsigned RESET_CYCLES    = 7;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned PHASE_QUOTA     = 125;
  localparam int unsigned CYCLE_LIMIT     = 250000;

  // Indexes past the register list; writes there must have no effect.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  typedef struct packed {
    scad_pulse_t       min_thr;
    scad_pulse_t       max_thr;
    logic [CODE_W-1:0] arm_pat;
    logic [CODE_W-1:0] disarm_pat;
    logic [CODE_W-1:0] idle_pat;
    logic [IDLE_W-1:0] auto_limit;
  } arm_settings_t;

  localparam arm_settings_t RESET_SETTINGS = '{MIN_THR_RESET, MAX_THR_RESET,
      ARM_PAT_RESET, DISARM_PAT_RESET, IDLE_PAT_RESET, AUTO_LIMIT_RESET};

  class arm_status_tracker;
    arm_settings_t     regs;
    logic [CODE_W-1:0] prev_code;
    logic [HOLD_W-1:0] hold_cnt;
    logic [IDLE_W-1:0] idle_cnt;
    logic              armed;
    scad_result_t      pending_status[$];
    int unsigned       errors;

    function new(arm_settings_t at_reset);
      regs      = at_reset;
      prev_code = '0;
      hold_cnt  = '0;
      idle_cnt  = '0;
      armed     = 1'b0;
      errors    = 0;
    endfunction

    static function logic [1:0] chan_code(scad_pulse_t p, arm_settings_t s);
      logic [1:0] c;
      c[BIT_ABOVE_MIN] = (p > s.min_thr);
      c[BIT_BELOW_MAX] = (p < s.max_thr);
      return c;
    endfunction

    static function logic [CODE_W-1:0] code_of(scad_pulses_t p, arm_settings_t s);
      logic [CODE_W-1:0] c;
      for (int n = 0; n < NUM_CHAN; n++) c[2*n +: 2] = chan_code(p[n], s);
      return c;
    endfunction

    function void note_sample(scad_pulses_t p);
      scad_result_t      st;
      logic [CODE_W-1:0] code;
      code = code_of(p, regs);
      st   = '0;
      if (code == prev_code) begin
        if (hold_cnt < HOLD_SATURATE) hold_cnt = hold_cnt + 1'b1;
      end else begin
        hold_cnt = '0;
      end
      prev_code = code;
      if (hold_cnt == HOLD_TRIGGER) begin
        if (armed) begin
          if (code == regs.disarm_pat) begin
            armed           = 1'b0;
            st.disarm_event = 1'b1;
          end
        end else if (code == regs.arm_pat) begin
          armed        = 1'b1;
          st.arm_event = 1'b1;
        end
      end
      // The idle rule also runs on the very sample that armed the block.
      if (armed) begin
        if (code == regs.idle_pat) begin
          if (idle_cnt < regs.auto_limit) begin
            idle_cnt = idle_cnt + 1'b1;
          end else begin
            armed                = 1'b0;
            st.auto_disarm_event = 1'b1;
          end
        end else begin
          idle_cnt = '0;
        end
      end
      st.armed_now  = armed;
      st.stick_code = code;
      pending_status.push_back(st);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_status(scad_result_t got);
      scad_result_t want;
      if (pending_status.size() == 0) begin
        $error("status result with no sample outstanding: %p", got);
        errors++;
        return;
      end
      want = pending_status.pop_front();
      compare_field("armed_now", 8'(want.armed_now), 8'(got.armed_now));
      compare_field("arm_event", 8'(want.arm_event), 8'(got.arm_event));
      compare_field("disarm_event", 8'(want.disarm_event), 8'(got.disarm_event));
      compare_field("auto_disarm_event", 8'(want.auto_disarm_event),
                    8'(got.auto_disarm_event));
      compare_field("stick_code", want.stick_code, got.stick_code);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  scad_in_if  in_ch ();
  scad_out_if out_ch ();

  stick_command_arm_disarm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  arm_status_tracker tracker;
  int unsigned       sender_idle_pct   = 32;
  int unsigned       receiver_idle_pct = 65;
  logic              hold_off_req      = 1'b0;
  int unsigned       samples_sent      = 0;
  int unsigned       cycle_count       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : status_monitor
    scad_result_t seen;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.armed_now         = out_ch.armed_now;
      seen.arm_event         = out_ch.arm_event;
      seen.disarm_event      = out_ch.disarm_event;
      seen.auto_disarm_event = out_ch.auto_disarm_event;
      seen.stick_code        = out_ch.stick_code;
      tracker.check_status(seen);
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so that
  // the block fills up while the sender keeps offering samples.
  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready = 1'b0;
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // Pulses are drawn in each band, around the thresholds or at random, so every code turns up.
  function automatic scad_pulse_t candidate_pulse(arm_settings_t s);
    scad_pulse_t p;
    case ($urandom_range(0, 6))
      0:       p = scad_pulse_t'($urandom_range(0, s.min_thr));
      1:       p = scad_pulse_t'($urandom_range(s.min_thr, s.max_thr));
      2:       p = scad_pulse_t'($urandom_range(s.max_thr, 16'hFFFF));
      3:       p = scad_pulse_t'($urandom);
      4:       p = s.min_thr + scad_pulse_t'($urandom_range(0, 2)) - 16'd1;
      5:       p = s.max_thr + scad_pulse_t'($urandom_range(0, 2)) - 16'd1;
      default: p = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return p;
  endfunction

  function automatic scad_pulses_t random_pulses(arm_settings_t s);
    scad_pulses_t p;
    for (int n = 0; n < NUM_CHAN; n++) p[n] = candidate_pulse(s);
    return p;
  endfunction

  function automatic logic [CODE_W-1:0] random_pattern(arm_settings_t s);
    return arm_status_tracker::code_of(random_pulses(s), s);
  endfunction

  // Random pulses that give the wanted code, where the thresholds allow it.
  function automatic scad_pulses_t pulses_for_code(logic [CODE_W-1:0] pattern,
                                                   arm_settings_t s);
    scad_pulses_t p;
    for (int n = 0; n < NUM_CHAN; n++) begin
      p[n] = candidate_pulse(s);
      for (int t = 0; t < 48 && arm_status_tracker::chan_code(p[n], s) != pattern[2*n +: 2];
           t++) p[n] = candidate_pulse(s);
    end
    return p;
  endfunction

  function automatic scad_pulses_t sample_of(scad_pulse_t c0, scad_pulse_t c1,
                                             scad_pulse_t c2, scad_pulse_t c3);
    scad_pulses_t p;
    p[0] = c0;
    p[1] = c1;
    p[2] = c2;
    p[3] = c3;
    return p;
  endfunction

  function automatic arm_settings_t spread_settings(logic [IDLE_W-1:0] limit);
    arm_settings_t s;
    s.min_thr    = scad_pulse_t'($urandom_range(200, 2500));
    s.max_thr    = s.min_thr + scad_pulse_t'($urandom_range(2, 2500));
    s.arm_pat    = random_pattern(s);
    s.disarm_pat = random_pattern(s);
    s.idle_pat   = random_pattern(s);
    s.auto_limit = limit;
    return s;
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_sample(scad_pulses_t p);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.chan0_pulse = p[0];
    in_ch.chan1_pulse = p[1];
    in_ch.chan2_pulse = p[2];
    in_ch.chan3_pulse = p[3];
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_sample(p);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic hold_pattern(logic [CODE_W-1:0] pattern, int unsigned len);
    repeat (len) send_sample(pulses_for_code(pattern, tracker.regs));
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (tracker.pending_status.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called with the block idle; the enable stays high across the list.
  task automatic program_registers(arm_settings_t s);
    cfg_we    = 1'b1;
    cfg_index = CFG_MIN_THRESHOLD;
    cfg_data  = s.min_thr;
    @(negedge clk);
    cfg_index = CFG_MAX_THRESHOLD;
    cfg_data  = s.max_thr;
    @(negedge clk);
    cfg_index = CFG_ARM_PATTERN;
    cfg_data  = CFG_DATA_W'(s.arm_pat);
    @(negedge clk);
    cfg_index = CFG_DISARM_PATTERN;
    cfg_data  = CFG_DATA_W'(s.disarm_pat);
    @(negedge clk);
    cfg_index = CFG_IDLE_PATTERN;
    cfg_data  = CFG_DATA_W'(s.idle_pat);
    @(negedge clk);
    cfg_index = CFG_AUTO_DISARM_LIMIT;
    cfg_data  = s.auto_limit;
    @(negedge clk);
    cfg_index = CFG_UNUSED_LO;
    cfg_data  = CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_index = CFG_UNUSED_HI;
    cfg_data  = CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_we      = 1'b0;
    tracker.regs = s;
  endtask

  // Each phase opens with a command held long enough to trigger, then mixes
  // further held commands, idle runs, short runs and loose samples.
  task automatic exercise(int unsigned quota);
    int unsigned       start_count;
    int unsigned       len;
    logic [CODE_W-1:0] pattern;
    start_count = samples_sent;
    hold_pattern(tracker.armed ? tracker.regs.disarm_pat : tracker.regs.arm_pat,
                 $urandom_range(151, 154));
    while (samples_sent - start_count < quota) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          pattern = tracker.armed ? tracker.regs.disarm_pat : tracker.regs.arm_pat;
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(245, 260)
                                            : $urandom_range(149, 156);
          hold_pattern(pattern, len);
        end
        2: begin
          len = (tracker.regs.auto_limit < 16)
                ? int'(tracker.regs.auto_limit) + $urandom_range(0, 3)
                : $urandom_range(1, 12);
          hold_pattern(tracker.regs.idle_pat, len);
        end
        3:       hold_pattern(random_pattern(tracker.regs), $urandom_range(1, 10));
        default: repeat ($urandom_range(1, 6)) send_sample(random_pulses(tracker.regs));
      endcase
    end
  endtask

  initial begin : stimulus
    arm_settings_t s;
    tracker           = new(RESET_SETTINGS);
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.chan0_pulse = '0;
    in_ch.chan1_pulse = '0;
    in_ch.chan2_pulse = '0;
    in_ch.chan3_pulse = '0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_MIN_THRESHOLD;
    cfg_data          = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Crossed extremes force code zero, which matches the cleared last code,
    // so even the first sample counts as a repeat.
    s         = RESET_SETTINGS;
    s.min_thr = '1;
    s.max_thr = '0;
    program_registers(s);
    send_sample('0);
    send_sample('1);
    send_sample(sample_of(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE));
    drain_results();

    program_registers(RESET_SETTINGS);
    send_sample('0);
    send_sample('1);
    send_sample(sample_of(16'd1100, 16'd1100, 16'd1100, 16'd1100));
    send_sample(sample_of(16'd1101, 16'd1101, 16'd1101, 16'd1101));
    send_sample(sample_of(16'd1899, 16'd1899, 16'd1899, 16'd1899));
    send_sample(sample_of(16'd1900, 16'd1900, 16'd1900, 16'd1900));
    send_sample(sample_of(16'd1100, 16'd1101, 16'd1899, 16'd1900));
    send_sample(sample_of(16'd1900, 16'd1899, 16'd1101, 16'd1100));
    send_sample(sample_of(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    send_sample(sample_of(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    send_sample(pulses_for_code(ARM_PAT_RESET, tracker.regs));
    send_sample(pulses_for_code(DISARM_PAT_RESET, tracker.regs));
    hold_pattern(IDLE_PAT_RESET, 2);
    drain_results();

    hold_off_req = 1'b1;
    exercise(PHASE_QUOTA);
    drain_results();
    program_registers(spread_settings(IDLE_W'($urandom_range(0, 3))));
    exercise(PHASE_QUOTA);
    drain_results();

    sender_idle_pct   = 65;
    receiver_idle_pct = 32;
    // Widest thresholds, zero limit, and arming on the idle pattern itself.
    s.min_thr    = '0;
    s.max_thr    = '1;
    s.arm_pat    = random_pattern(s);
    s.idle_pat   = s.arm_pat;
    s.disarm_pat = '1;
    s.auto_limit = '0;
    program_registers(s);
    exercise(PHASE_QUOTA);
    drain_results();
    // Crossed thresholds: the band between them codes as zero.
    s.min_thr    = 16'd3000;
    s.max_thr    = 16'd1000;
    s.arm_pat    = '0;
    s.disarm_pat = random_pattern(s);
    s.idle_pat   = random_pattern(s);
    s.auto_limit = IDLE_W'($urandom_range(0, 5));
    program_registers(s);
    exercise(PHASE_QUOTA);
    drain_results();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    program_registers(spread_settings('1));
    hold_off_req = 1'b1;
    exercise(PHASE_QUOTA);
    drain_results();
    s = spread_settings(IDLE_W'($urandom_range(0, 10)));
    if ($urandom_range(0, 1) == 1) s.idle_pat = s.arm_pat;
    program_registers(s);
    exercise(PHASE_QUOTA);
    drain_results();

    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/scad_pkg.sv
sv/scad_if.sv
sv/scad_stick_coder.sv
sv/stick_command_arm_disarm.sv
tb/tb_stick_command_arm_disarm.sv
